// File: rtl/tlh_pkg.sv
// Shared codes and hash constants for the two-level hash location table.
`timescale 1ns / 1ps
package tlh_pkg;
    localparam logic [2:0] FUNC_LOOKUP = 3'd0;
    localparam logic [2:0] FUNC_UPDATE = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_SET_SEAL = 3'd3;
    localparam logic [2:0] FUNC_QUERY_SEAL = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [31:0] NO_GROUP = 32'hFFFF_FFFF;
    localparam logic [31:0] NO_ITEM = 32'h0;
    localparam logic [31:0] GROUP_SALT = 32'h9e37_79b9;

    localparam logic [63:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;
endpackage

// File: rtl/tlh_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module tlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/tlh_hash.sv
// Multi-cycle 64-bit mix finalizer built on one shared 32x32 multiplier.
`timescale 1ns / 1ps
module tlh_hash import tlh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [63:0] o_hash
);
    logic [2:0]  r_step;
    logic [63:0] r_x;
    logic [63:0] r_acc;
    logic [63:0] r_hash;
    logic        r_done;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_c;
    logic [63:0] prod;
    logic [63:0] sum;

    always_comb begin
        mul_c = (r_step <= 3'd3) ? MIX_C1 : MIX_C2;
        mul_a = (r_step == 3'd3 || r_step == 3'd6) ? r_x[63:32] : r_x[31:0];
        mul_b = (r_step == 3'd2 || r_step == 3'd5) ? mul_c[63:32] : mul_c[31:0];
        prod = {32'b0, mul_a} * {32'b0, mul_b};
        if (r_step == 3'd1 || r_step == 3'd4) begin
            sum = prod;
        end else begin
            sum = r_acc + {prod[31:0], 32'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_step)
                3'd0: begin
                    if (i_start) begin
                        r_x <= i_x ^ (i_x >> 30);
                        r_step <= 3'd1;
                    end
                end
                3'd3: begin
                    r_x <= sum ^ (sum >> 27);
                    r_step <= 3'd4;
                end
                3'd6: begin
                    r_hash <= sum ^ (sum >> 33);
                    r_done <= 1'b1;
                    r_step <= 3'd0;
                end
                default: begin
                    r_acc <= sum;
                    r_step <= r_step + 3'd1;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hash = r_hash;
endmodule

// File: rtl/two_level_hash_location_table.sv
// Top level: two-level open-addressing group/item map over two RAMs.
// Rejected commands are answered without raising busy; others hash their keys and then
// read a RAM per group or item probe; a remove also re-hashes and re-places each cluster
// entry moved, and the wildcard lookup repeats the item probe per occupied group slot.
// One command at a time (busy high). Reset: synchronous active low; then a clearing
// pass sweeps all entries of both RAMs with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
module two_level_hash_location_table import tlh_pkg::*; #(
    parameter int GROUP_SLOTS = 16,
    parameter int ITEM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_group_key,
    input  logic [31:0] i_item_key,
    input  logic [31:0] i_item_value,
    input  logic        i_seal_in,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_group,
    output logic [31:0] o_out_key,
    output logic [31:0] o_out_value,
    output logic        o_out_sealed
);
    localparam int GAW = $clog2(GROUP_SLOTS);
    localparam int IW = $clog2(ITEM_SLOTS);
    localparam int IAW = GAW + IW;
    localparam int CW = IW + 1;
    localparam int GCW = GAW + 1;
    localparam int GWW = 32 + CW + 1;
    localparam int G_LIM = (GROUP_SLOTS * 7 + 9) / 10;
    localparam int I_LIM = (ITEM_SLOTS * 7 + 9) / 10;
    localparam logic [GCW-1:0] G_MAX = GCW'(G_LIM - 1);
    localparam logic [CW-1:0] I_MAX = CW'(I_LIM - 1);
    localparam logic [GAW-1:0] G_LAST = GAW'(GROUP_SLOTS - 1);
    localparam logic [IW-1:0] I_LAST = IW'(ITEM_SLOTS - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HI = 4'd2;
    localparam logic [3:0] S_HG = 4'd3;
    localparam logic [3:0] S_GRD = 4'd4;
    localparam logic [3:0] S_GCHK = 4'd5;
    localparam logic [3:0] S_WRD = 4'd6;
    localparam logic [3:0] S_WCHK = 4'd7;
    localparam logic [3:0] S_IRD = 4'd8;
    localparam logic [3:0] S_ICHK = 4'd9;
    localparam logic [3:0] S_RRD = 4'd10;
    localparam logic [3:0] S_RCHK = 4'd11;
    localparam logic [3:0] S_RHASH = 4'd12;
    localparam logic [3:0] S_RPRD = 4'd13;
    localparam logic [3:0] S_RPCHK = 4'd14;

    logic [3:0]     r_state, n_state;
    logic [IAW-1:0] r_clr, n_clr;
    logic [2:0]     r_func, n_func;
    logic [31:0]    r_gkey, n_gkey;
    logic [31:0]    r_ikey, n_ikey;
    logic [31:0]    r_val, n_val;
    logic           r_seal, n_seal;
    logic           r_wild, n_wild;
    logic [IW-1:0]  r_ih, n_ih;
    logic [GAW-1:0] r_gpos, n_gpos;
    logic [GAW-1:0] r_gn, n_gn;
    logic [GAW-1:0] r_g, n_g;
    logic [GAW-1:0] r_wg, n_wg;
    logic [GWW-1:0] r_gword, n_gword;
    logic [GCW-1:0] r_gcount, n_gcount;
    logic [IW-1:0]  r_ipos, n_ipos;
    logic [IW-1:0]  r_in, n_in;
    logic [IW-1:0]  r_nx, n_nx;
    logic [IW-1:0]  r_rn, n_rn;
    logic [31:0]    r_mk, n_mk;
    logic [31:0]    r_mv, n_mv;
    logic           r_strobe, n_strobe;
    logic [1:0]     r_status, n_status;
    logic [31:0]    r_og, n_og;
    logic [31:0]    r_ok, n_ok;
    logic [31:0]    r_ov, n_ov;
    logic           r_os, n_os;

    logic           h_start;
    logic [63:0]    h_x;
    logic           h_done;
    logic [63:0]    h_hash;

    logic           g_we;
    logic [GAW-1:0] g_waddr;
    logic [GWW-1:0] g_wdata;
    logic [GAW-1:0] g_raddr;
    logic [GWW-1:0] g_rdata;
    logic           im_we;
    logic [IAW-1:0] im_waddr;
    logic [63:0]    im_wdata;
    logic [IAW-1:0] im_raddr;
    logic [63:0]    im_rdata;

    logic [31:0]    gk;
    logic [CW-1:0]  gcnt;
    logic [CW-1:0]  wcnt;
    logic [31:0]    ik;
    logic [31:0]    iv;

    tlh_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_x     (h_x),
        .o_done  (h_done),
        .o_hash  (h_hash)
    );

    tlh_ram #(.WIDTH(GWW), .DEPTH(GROUP_SLOTS)) u_gmem (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    tlh_ram #(.WIDTH(64), .DEPTH(GROUP_SLOTS * ITEM_SLOTS)) u_imem (
        .i_clk   (i_clk),
        .i_we    (im_we),
        .i_waddr (im_waddr),
        .i_wdata (im_wdata),
        .i_raddr (im_raddr),
        .o_rdata (im_rdata)
    );

    assign gk = g_rdata[31:0];
    assign gcnt = g_rdata[32 +: CW];
    assign wcnt = r_gword[32 +: CW];
    assign ik = im_rdata[31:0];
    assign iv = im_rdata[63:32];

    assign g_raddr = (r_state == S_WRD) ? r_wg : r_gpos;

    always_comb begin
        case (r_state)
            S_RRD:   im_raddr = {r_g, r_nx};
            S_RPRD:  im_raddr = {r_g, r_ipos};
            default: im_raddr = {r_g, r_ipos};
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_func = r_func;
        n_gkey = r_gkey;
        n_ikey = r_ikey;
        n_val = r_val;
        n_seal = r_seal;
        n_wild = r_wild;
        n_ih = r_ih;
        n_gpos = r_gpos;
        n_gn = r_gn;
        n_g = r_g;
        n_wg = r_wg;
        n_gword = r_gword;
        n_gcount = r_gcount;
        n_ipos = r_ipos;
        n_in = r_in;
        n_nx = r_nx;
        n_rn = r_rn;
        n_mk = r_mk;
        n_mv = r_mv;
        n_strobe = 1'b0;
        n_status = r_status;
        n_og = r_og;
        n_ok = r_ok;
        n_ov = r_ov;
        n_os = r_os;
        h_start = 1'b0;
        h_x = {32'b0, r_ikey};
        g_we = 1'b0;
        g_waddr = r_g;
        g_wdata = r_gword;
        im_we = 1'b0;
        im_waddr = {r_g, r_ipos};
        im_wdata = 64'b0;

        case (r_state)
            S_CLEAR: begin
                g_we = 1'b1;
                g_waddr = r_clr[GAW-1:0];
                g_wdata = {1'b0, {CW{1'b0}}, NO_GROUP};
                im_we = 1'b1;
                im_waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == {IAW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_gkey = i_group_key;
                    n_ikey = i_item_key;
                    n_val = i_item_value;
                    n_seal = i_seal_in;
                    n_wild = (i_group_key == NO_GROUP);
                    n_status = ST_INVALID;
                    n_og = 32'b0;
                    n_ok = 32'b0;
                    n_ov = 32'b0;
                    n_os = 1'b0;
                    case (i_func)
                        FUNC_LOOKUP, FUNC_UPDATE, FUNC_REMOVE: begin
                            if (i_item_key == NO_ITEM ||
                                (i_func != FUNC_LOOKUP && i_group_key == NO_GROUP)) begin
                                n_strobe = 1'b1;
                            end else begin
                                h_start = 1'b1;
                                h_x = {32'b0, i_item_key};
                                n_state = S_HI;
                            end
                        end
                        FUNC_SET_SEAL, FUNC_QUERY_SEAL: begin
                            if (i_group_key == NO_GROUP) begin
                                n_strobe = 1'b1;
                            end else begin
                                h_start = 1'b1;
                                h_x = {32'b0, i_group_key ^ GROUP_SALT};
                                n_state = S_HG;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            S_HI: begin
                if (h_done) begin
                    n_ih = h_hash[IW-1:0];
                    if (r_wild) begin
                        n_wg = '0;
                        n_state = S_WRD;
                    end else begin
                        h_start = 1'b1;
                        h_x = {32'b0, r_gkey ^ GROUP_SALT};
                        n_state = S_HG;
                    end
                end
            end
            S_HG: begin
                if (h_done) begin
                    n_gpos = h_hash[GAW-1:0];
                    n_gn = '0;
                    n_state = S_GRD;
                end
            end
            S_GRD: n_state = S_GCHK;
            S_GCHK: begin
                n_g = r_gpos;
                n_ipos = r_ih;
                n_in = '0;
                if (gk == r_gkey) begin
                    n_gword = g_rdata;
                    case (r_func)
                        FUNC_SET_SEAL: begin
                            g_we = 1'b1;
                            g_waddr = r_gpos;
                            g_wdata = {r_seal, gcnt, r_gkey};
                            n_status = ST_OK;
                            n_strobe = 1'b1;
                            n_state = S_IDLE;
                        end
                        FUNC_QUERY_SEAL: begin
                            n_status = ST_OK;
                            n_os = g_rdata[GWW-1];
                            n_strobe = 1'b1;
                            n_state = S_IDLE;
                        end
                        default: n_state = S_IRD;
                    endcase
                end else if (gk == NO_GROUP || r_gn == G_LAST) begin
                    if (r_func == FUNC_UPDATE || r_func == FUNC_SET_SEAL) begin
                        if (gk == NO_GROUP && r_gcount < G_MAX) begin
                            // create the group in the empty slot
                            g_we = 1'b1;
                            g_waddr = r_gpos;
                            g_wdata = {(r_func == FUNC_SET_SEAL) & r_seal, {CW{1'b0}},
                                       r_gkey};
                            n_gword = {1'b0, {CW{1'b0}}, r_gkey};
                            n_gcount = r_gcount + 1'b1;
                            if (r_func == FUNC_UPDATE) begin
                                n_state = S_IRD;
                            end else begin
                                n_status = ST_OK;
                                n_strobe = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_status = ST_FULL;
                            n_strobe = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_status = ST_MISS;
                        n_strobe = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_gpos = r_gpos + 1'b1;
                    n_gn = r_gn + 1'b1;
                    n_state = S_GRD;
                end
            end
            S_WRD: n_state = S_WCHK;
            S_WCHK: begin
                if (gk == NO_GROUP) begin
                    if (r_wg == G_LAST) begin
                        n_status = ST_MISS;
                        n_strobe = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_wg = r_wg + 1'b1;
                        n_state = S_WRD;
                    end
                end else begin
                    n_g = r_wg;
                    n_gkey = gk;
                    n_ipos = r_ih;
                    n_in = '0;
                    n_state = S_IRD;
                end
            end
            S_IRD: n_state = S_ICHK;
            S_ICHK: begin
                if (ik == r_ikey) begin
                    case (r_func)
                        FUNC_LOOKUP: begin
                            n_status = ST_OK;
                            n_og = r_gkey;
                            n_ok = r_ikey;
                            n_ov = iv;
                            n_strobe = 1'b1;
                            n_state = S_IDLE;
                        end
                        FUNC_UPDATE: begin
                            im_we = 1'b1;
                            im_wdata = {r_val, r_ikey};
                            n_status = ST_OK;
                            n_strobe = 1'b1;
                            n_state = S_IDLE;
                        end
                        default: begin
                            // remove: clear entry, then re-place the rest of the cluster
                            im_we = 1'b1;
                            g_we = (wcnt != '0);
                            g_wdata = {r_gword[GWW-1], wcnt - 1'b1, r_gword[31:0]};
                            n_nx = r_ipos + 1'b1;
                            n_rn = '0;
                            n_state = S_RRD;
                        end
                    endcase
                end else if (ik == NO_ITEM || r_in == I_LAST) begin
                    n_strobe = 1'b1;
                    n_state = S_IDLE;
                    n_status = ST_MISS;
                    if (r_func == FUNC_UPDATE) begin
                        if (ik == NO_ITEM && wcnt < I_MAX) begin
                            im_we = 1'b1;
                            im_wdata = {r_val, r_ikey};
                            g_we = 1'b1;
                            g_wdata = {r_gword[GWW-1], wcnt + 1'b1, r_gword[31:0]};
                            n_status = ST_OK;
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else if (r_func == FUNC_LOOKUP && r_wild && r_wg != G_LAST) begin
                        n_strobe = 1'b0;
                        n_wg = r_wg + 1'b1;
                        n_state = S_WRD;
                    end
                end else begin
                    n_ipos = r_ipos + 1'b1;
                    n_in = r_in + 1'b1;
                    n_state = S_IRD;
                end
            end
            S_RRD: n_state = S_RCHK;
            S_RCHK: begin
                if (ik == NO_ITEM || r_rn == I_LAST) begin
                    n_status = ST_OK;
                    n_strobe = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_mk = ik;
                    n_mv = iv;
                    im_we = 1'b1;
                    im_waddr = {r_g, r_nx};
                    h_start = 1'b1;
                    h_x = {32'b0, ik};
                    n_state = S_RHASH;
                end
            end
            S_RHASH: begin
                if (h_done) begin
                    n_ipos = h_hash[IW-1:0];
                    n_in = '0;
                    n_state = S_RPRD;
                end
            end
            S_RPRD: n_state = S_RPCHK;
            S_RPCHK: begin
                if (ik == r_mk || ik == NO_ITEM || r_in == I_LAST) begin
                    im_we = 1'b1;
                    im_wdata = {r_mv, r_mk};
                    if (!(ik == r_mk || ik == NO_ITEM)) begin
                        im_waddr = {r_g, r_nx};
                    end
                    n_nx = r_nx + 1'b1;
                    n_rn = r_rn + 1'b1;
                    n_state = S_RRD;
                end else begin
                    n_ipos = r_ipos + 1'b1;
                    n_in = r_in + 1'b1;
                    n_state = S_RPRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_gcount <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_gcount <= n_gcount;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_gkey <= n_gkey;
        r_ikey <= n_ikey;
        r_val <= n_val;
        r_seal <= n_seal;
        r_wild <= n_wild;
        r_ih <= n_ih;
        r_gpos <= n_gpos;
        r_gn <= n_gn;
        r_g <= n_g;
        r_wg <= n_wg;
        r_gword <= n_gword;
        r_ipos <= n_ipos;
        r_in <= n_in;
        r_nx <= n_nx;
        r_rn <= n_rn;
        r_mk <= n_mk;
        r_mv <= n_mv;
        r_status <= n_status;
        r_og <= n_og;
        r_ok <= n_ok;
        r_ov <= n_ov;
        r_os <= n_os;
    end

    assign busy = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_out_group = r_og;
    assign o_out_key = r_ok;
    assign o_out_value = r_ov;
    assign o_out_sealed = r_os;

`ifndef SYNTHESIS
    a_gcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gcount < GCW'(G_LIM))
        else $error("group count exceeds load limit");
    a_accept_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted command neither answered nor in progress");
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !o_strobe)
        else $error("result during clearing pass");
`endif
endmodule

// File: tb/tb_two_level_hash_location_table.sv
// Self-checking testbench for the two-level hash location table.
`timescale 1ns / 1ps
module tb_two_level_hash_location_table;
    import tlh_pkg::*;

    localparam int GSLOTS = 16;
    localparam int ISLOTS = 16;
    localparam int N_RANDOM = 930;
    localparam longint CYCLE_LIMIT = 5_000_000;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] gkey;
        logic [31:0] ikey;
        logic [31:0] ival;
        logic        seal;
    } t_command;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] grp;
        logic [31:0] key;
        logic [31:0] value;
        logic        sealed;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [31:0] i_group_key = '0;
    logic [31:0] i_item_key = '0;
    logic [31:0] i_item_value = '0;
    logic        i_seal_in = 1'b0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [31:0] o_out_group;
    logic [31:0] o_out_key;
    logic [31:0] o_out_value;
    logic        o_out_sealed;

    two_level_hash_location_table #(.GROUP_SLOTS(GSLOTS), .ITEM_SLOTS(ISLOTS)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_group_key(i_group_key), .i_item_key(i_item_key),
        .i_item_value(i_item_value), .i_seal_in(i_seal_in),
        .o_strobe(o_strobe), .o_status(o_status), .o_out_group(o_out_group),
        .o_out_key(o_out_key), .o_out_value(o_out_value), .o_out_sealed(o_out_sealed)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the table contents
    logic [31:0] sh_gkeys [GSLOTS];
    logic        sh_sealed [GSLOTS];
    int unsigned sh_gcount;
    logic [31:0] sh_ikeys [GSLOTS][ISLOTS];
    logic [31:0] sh_ivals [GSLOTS][ISLOTS];
    int unsigned sh_icount [GSLOTS];

    t_command pending_cmds[$];
    t_answer  expected_answers[$];
    int       error_count = 0;
    int       answers_seen = 0;
    int       status_seen [4];
    int       func_seen [8];
    longint   cycle_count = 0;
    bit       stimulus_done = 1'b0;
    int       gap_left = 0;

    // keys drawn from small pools so tables fill and collide
    logic [31:0] group_pool [12];
    logic [31:0] item_pool [24];

    function automatic logic [63:0] mix64(logic [63:0] x);
        x = x ^ (x >> 30);
        x = x * MIX_C1;
        x = x ^ (x >> 27);
        x = x * MIX_C2;
        x = x ^ (x >> 33);
        return x;
    endfunction

    // 1 found, 0 empty slot, -1 neither
    function automatic int find_group(logic [31:0] key, output int slot);
        int pos;
        pos = int'(mix64({32'd0, key ^ GROUP_SALT}) & 64'(GSLOTS - 1));
        slot = 0;
        for (int n = 0; n < GSLOTS; n++) begin
            if (sh_gkeys[pos] == key) begin
                slot = pos;
                return 1;
            end
            if (sh_gkeys[pos] == NO_GROUP) begin
                slot = pos;
                return 0;
            end
            pos = (pos + 1) % GSLOTS;
        end
        return -1;
    endfunction

    function automatic int find_item(int g, logic [31:0] key, output int slot);
        int pos;
        pos = int'(mix64({32'd0, key}) & 64'(ISLOTS - 1));
        slot = 0;
        for (int n = 0; n < ISLOTS; n++) begin
            if (sh_ikeys[g][pos] == key) begin
                slot = pos;
                return 1;
            end
            if (sh_ikeys[g][pos] == NO_ITEM) begin
                slot = pos;
                return 0;
            end
            pos = (pos + 1) % ISLOTS;
        end
        return -1;
    endfunction

    function automatic logic [1:0] open_group(logic [31:0] key, output int g);
        int r;
        int slot;
        r = find_group(key, slot);
        g = slot;
        if (r == 1) return ST_OK;
        if (r < 0 || (sh_gcount + 1) * 10 >= GSLOTS * 7) return ST_FULL;
        sh_gkeys[slot] = key;
        sh_sealed[slot] = 1'b0;
        sh_gcount++;
        return ST_OK;
    endfunction

    function automatic t_answer apply_command(t_command c);
        t_answer a;
        int g;
        int s;
        int r;
        int nx;
        int d;
        logic [31:0] k;
        logic [31:0] v;
        a = '0;
        a.status = ST_INVALID;
        case (c.func)
            FUNC_LOOKUP: if (c.ikey != NO_ITEM) begin
                a.status = ST_MISS;
                if (c.gkey != NO_GROUP) begin
                    if (find_group(c.gkey, g) == 1 && find_item(g, c.ikey, s) == 1) begin
                        a.status = ST_OK;
                        a.grp = c.gkey;
                        a.key = c.ikey;
                        a.value = sh_ivals[g][s];
                    end
                end else begin
                    for (g = 0; g < GSLOTS; g++) begin
                        if (sh_gkeys[g] != NO_GROUP && find_item(g, c.ikey, s) == 1) begin
                            a.status = ST_OK;
                            a.grp = sh_gkeys[g];
                            a.key = c.ikey;
                            a.value = sh_ivals[g][s];
                            break;
                        end
                    end
                end
            end
            FUNC_UPDATE: if (c.ikey != NO_ITEM && c.gkey != NO_GROUP) begin
                a.status = open_group(c.gkey, g);
                if (a.status == ST_OK) begin
                    r = find_item(g, c.ikey, s);
                    if (r == 1) begin
                        sh_ivals[g][s] = c.ival;
                    end else if (r == 0 && (sh_icount[g] + 1) * 10 < ISLOTS * 7) begin
                        sh_ikeys[g][s] = c.ikey;
                        sh_ivals[g][s] = c.ival;
                        sh_icount[g]++;
                    end else begin
                        a.status = ST_FULL;
                    end
                end
            end
            FUNC_REMOVE: if (c.ikey != NO_ITEM && c.gkey != NO_GROUP) begin
                a.status = ST_MISS;
                if (find_group(c.gkey, g) == 1 && find_item(g, c.ikey, s) == 1) begin
                    a.status = ST_OK;
                    sh_ikeys[g][s] = NO_ITEM;
                    sh_ivals[g][s] = '0;
                    if (sh_icount[g] > 0) sh_icount[g]--;
                    nx = (s + 1) % ISLOTS;
                    // pull the rest of the cluster out and reinsert it
                    for (int n = 0; n + 1 < ISLOTS; n++) begin
                        k = sh_ikeys[g][nx];
                        v = sh_ivals[g][nx];
                        if (k == NO_ITEM) break;
                        sh_ikeys[g][nx] = NO_ITEM;
                        sh_ivals[g][nx] = '0;
                        if (find_item(g, k, d) < 0) d = nx;
                        sh_ikeys[g][d] = k;
                        sh_ivals[g][d] = v;
                        nx = (nx + 1) % ISLOTS;
                    end
                end
            end
            FUNC_SET_SEAL: if (c.gkey != NO_GROUP) begin
                a.status = open_group(c.gkey, g);
                if (a.status == ST_OK) sh_sealed[g] = c.seal;
            end
            FUNC_QUERY_SEAL: if (c.gkey != NO_GROUP) begin
                if (find_group(c.gkey, g) == 1) begin
                    a.status = ST_OK;
                    a.sealed = sh_sealed[g];
                end else begin
                    a.status = ST_MISS;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic t_command make_command(logic [2:0] f, logic [31:0] gk,
                                              logic [31:0] ik, logic [31:0] iv, logic sl);
        t_command c;
        c.func = f;
        c.gkey = gk;
        c.ikey = ik;
        c.ival = iv;
        c.seal = sl;
        return c;
    endfunction

    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_command random_command();
        t_command c;
        int p;
        p = $urandom_range(0, 99);
        c.ival = $urandom();
        c.seal = 1'($urandom_range(0, 1));
        c.gkey = group_pool[$urandom_range(0, 11)];
        c.ikey = item_pool[$urandom_range(0, 23)];
        if (p < 35) c.func = FUNC_UPDATE;
        else if (p < 60) c.func = FUNC_LOOKUP;
        else if (p < 78) c.func = FUNC_REMOVE;
        else if (p < 86) c.func = FUNC_SET_SEAL;
        else if (p < 94) c.func = FUNC_QUERY_SEAL;
        else c.func = 3'($urandom_range(5, 7));
        // noise: fully random keys, wildcard and zero keys
        p = $urandom_range(0, 99);
        if (p < 6) c.gkey = $urandom();
        else if (p < 14) c.gkey = NO_GROUP;
        p = $urandom_range(0, 99);
        if (p < 6) c.ikey = $urandom();
        else if (p < 10) c.ikey = NO_ITEM;
        return c;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", answers_seen, field, got, want);
        error_count++;
    endtask

    task automatic drive_next();
        t_command c;
        c = pending_cmds.pop_front();
        expected_answers.push_back(apply_command(c));
        func_seen[c.func]++;
        start <= 1'b1;
        i_func <= c.func;
        i_group_key <= c.gkey;
        i_item_key <= c.ikey;
        i_item_value <= c.ival;
        i_seal_in <= c.seal;
    endtask

    initial begin
        for (int g = 0; g < GSLOTS; g++) begin
            sh_gkeys[g] = NO_GROUP;
            sh_sealed[g] = 1'b0;
            sh_icount[g] = 0;
            for (int i = 0; i < ISLOTS; i++) begin
                sh_ikeys[g][i] = NO_ITEM;
                sh_ivals[g][i] = '0;
            end
        end
        sh_gcount = 0;
        for (int i = 0; i < 12; i++) group_pool[i] = $urandom();
        group_pool[0] = 32'h0;
        group_pool[1] = 32'hFFFF_FFFE;
        group_pool[2] = 32'h5555_5555;
        group_pool[3] = 32'hAAAA_AAAA;
        for (int i = 0; i < 24; i++) item_pool[i] = $urandom() | 32'h1;
        item_pool[0] = 32'h1;
        item_pool[1] = 32'hFFFF_FFFF;
        item_pool[2] = 32'hAAAA_AAAA;
        item_pool[3] = 32'h5555_5555;

        // directed: invalid keys, extremes, every function, misses
        pending_cmds.push_back(make_command(FUNC_LOOKUP, NO_GROUP, 32'h1, 0, 0));
        pending_cmds.push_back(make_command(FUNC_LOOKUP, 32'h0, NO_ITEM, 0, 0));
        pending_cmds.push_back(make_command(FUNC_UPDATE, NO_GROUP, 32'h1, 32'h1, 0));
        pending_cmds.push_back(make_command(FUNC_UPDATE, 32'h0, NO_ITEM, 32'h1, 0));
        pending_cmds.push_back(make_command(FUNC_UPDATE, 32'h0, 32'h1, 32'hFFFF_FFFF, 1));
        pending_cmds.push_back(make_command(FUNC_UPDATE, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                                            32'h0, 0));
        pending_cmds.push_back(make_command(FUNC_UPDATE, 32'h0, 32'h1, 32'h5555_AAAA, 0));
        pending_cmds.push_back(make_command(FUNC_LOOKUP, 32'h0, 32'h1, 0, 0));
        pending_cmds.push_back(make_command(FUNC_LOOKUP, NO_GROUP, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(make_command(FUNC_LOOKUP, 32'h0, 32'hFFFF_FFFF, 0, 0));
        pending_cmds.push_back(make_command(FUNC_QUERY_SEAL, 32'h7, 0, 0, 0));
        pending_cmds.push_back(make_command(FUNC_QUERY_SEAL, NO_GROUP, 0, 0, 0));
        pending_cmds.push_back(make_command(FUNC_SET_SEAL, NO_GROUP, 0, 0, 1));
        pending_cmds.push_back(make_command(FUNC_SET_SEAL, 32'h7, 0, 0, 1));
        pending_cmds.push_back(make_command(FUNC_QUERY_SEAL, 32'h7, 0, 0, 0));
        pending_cmds.push_back(make_command(FUNC_SET_SEAL, 32'h7, 0, 0, 0));
        pending_cmds.push_back(make_command(FUNC_QUERY_SEAL, 32'h7, 0, 0, 0));
        pending_cmds.push_back(make_command(FUNC_REMOVE, NO_GROUP, 32'h1, 0, 0));
        pending_cmds.push_back(make_command(FUNC_REMOVE, 32'h0, NO_ITEM, 0, 0));
        pending_cmds.push_back(make_command(FUNC_REMOVE, 32'h1234, 32'h1, 0, 0));
        pending_cmds.push_back(make_command(FUNC_REMOVE, 32'h0, 32'h1, 0, 0));
        pending_cmds.push_back(make_command(FUNC_REMOVE, 32'h0, 32'h1, 0, 0));
        pending_cmds.push_back(make_command(3'd5, 32'h0, 32'h1, 0, 1));
        pending_cmds.push_back(make_command(3'd7, 32'h0, 32'h1, 0, 1));
        // fill one group until it reports full
        for (int i = 0; i < 14; i++)
            pending_cmds.push_back(make_command(FUNC_UPDATE, 32'h5555_5555, item_pool[i],
                                                $urandom(), 0));
        // create many groups to reach group-level full
        for (int i = 0; i < 14; i++)
            pending_cmds.push_back(make_command(FUNC_SET_SEAL, 32'h100 + i, 0, 0, 1));
        for (int i = 0; i < N_RANDOM; i++) pending_cmds.push_back(random_command());
        stimulus_done = 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count < 5) begin
            i_rst_n <= 1'b0;
        end else begin
            i_rst_n <= 1'b1;
            if (start && !busy) begin
                // transaction accepted this edge
                if (gap_left == 0 && pending_cmds.size() > 0 && draw_gap() == 0)
                    drive_next();
                else begin
                    start <= 1'b0;
                    gap_left <= draw_gap();
                end
            end else if (!start && i_rst_n) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else if (pending_cmds.size() > 0) drive_next();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_strobe) begin
            if (expected_answers.size() == 0) begin
                $display("UNEXPECTED result with nothing pending");
                error_count++;
            end else begin
                want = expected_answers.pop_front();
                status_seen[want.status]++;
                if (o_status != want.status) report_mismatch("status", o_status, want.status);
                if (o_out_group != want.grp) report_mismatch("out_group", o_out_group, want.grp);
                if (o_out_key != want.key) report_mismatch("out_key", o_out_key, want.key);
                if (o_out_value != want.value)
                    report_mismatch("out_value", o_out_value, want.value);
                if (o_out_sealed != want.sealed)
                    report_mismatch("out_sealed", o_out_sealed, want.sealed);
            end
            answers_seen++;
        end
    end

    initial begin
        wait (stimulus_done);
        while (pending_cmds.size() > 0 || start || expected_answers.size() > 0) begin
            @(posedge i_clk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout at cycle %0d", cycle_count);
                $display("DONE: errors detected");
                $finish;
            end
        end
        repeat (200) @(posedge i_clk);
        $display("Checked %0d results: ok %0d, miss %0d, invalid %0d, full %0d",
                 answers_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("Commands: lookup %0d update %0d remove %0d set %0d query %0d other %0d",
                 func_seen[0], func_seen[1], func_seen[2], func_seen[3], func_seen[4],
                 func_seen[5] + func_seen[6] + func_seen[7]);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/tlh_pkg.sv
rtl/tlh_ram.sv
rtl/tlh_hash.sv
rtl/two_level_hash_location_table.sv
tb/tb_two_level_hash_location_table.sv
